// File: rtl/core/smeu_pkg.sv
// ============================================================================
// Stack machine execute unit - shared definitions
// Opcode and status codes, field widths and the result record.
// ============================================================================
package smeu_pkg;

    localparam int OPCODE_W  = 4;
    localparam int WORD_W    = 64;
    localparam int IADDR_W   = 16;
    localparam int STATUS_W  = 3;

    // tdata widths, rounded up to whole bytes
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 4;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH   = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_DROP   = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_DUP    = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_SWAP   = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_OVER   = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_NOT    = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_EQUAL  = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_LT     = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_JUMP   = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_JUMPIF = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_ADD    = 4'd10;
    localparam logic [OPCODE_W-1:0] OP_PRINT  = 4'd11;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADJUMP   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ILLEGAL   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HALTED    = 3'd5;

    // One result record
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IADDR_W-1:0]  next_address;
        logic                print_valid;
        logic [WORD_W-1:0]   print_value;
        logic                halted;
        logic                finished;
    } result_t;

endpackage

// File: rtl/core/stack_machine_execute_unit.sv
// ============================================================================
// Stack machine execute unit
// Executes one stack instruction per request on a bounded 64-bit operand
// stack held in a synchronous RAM, with the top two entries cached.
// ============================================================================
//
//  Channel   Direction  Contents
//  -------   ---------  ------------------------------------------------------
//  s_*       in         instruction: tuser opcode, tdata operand
//  m_*       out        result: tuser status/print flag, tdata address/value,
//                       tlast finished
//  cfg_*     in         program length register, write only
//
//  One request per cycle while results are taken; each request gives one
//  result, registered for the next cycle. The second-entry refill does not
//  limit the rate: a pop reads the RAM entry below the cached pair, and the
//  read data is forwarded into the next instruction, so no bubble is added.
//  Reset clears the stack pointer, instruction pointer, halt flag and the
//  program length; RAM contents are not cleared.
//  A stalled result holds in the output register, and s_tready drops then.
//
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // configuration
    input  logic                          cfg_wr_en,
    input  logic [smeu_pkg::IADDR_W-1:0]  cfg_wr_data,   // program_length

    // instruction stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [smeu_pkg::S_TDATA_W-1:0] s_tdata,      // [63:0] operand
    input  logic [smeu_pkg::OPCODE_W-1:0] s_tuser,       // [3:0] opcode

    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [smeu_pkg::M_TDATA_W-1:0] m_tdata,      // [15:0] next_address,
                                                         // [79:16] print_value,
                                                         // [80] halted, [87:81] 0
    output logic [smeu_pkg::M_TUSER_W-1:0] m_tuser,      // [2:0] status,
                                                         // [3] print_valid
    output logic                          m_tlast        // finished
);

    import smeu_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);

    // ------------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0]  stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0]  rd_data_reg;

    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic [WORD_W-1:0]  tos_reg,  tos_next;
    logic [WORD_W-1:0]  nos_reg,  nos_next;
    logic               fill_reg, fill_next;
    logic [IADDR_W-1:0] ip_reg,   ip_next;
    logic               halt_reg, halt_next;
    logic [IADDR_W-1:0] plen_reg;

    logic               m_tvalid_reg, m_tvalid_next;
    result_t            res_reg, res_next;

    // ------------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------------
    logic in_acc;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;

    // Second entry: forwarded RAM data right after a pop
    logic [WORD_W-1:0] nos_eff;
    assign nos_eff = fill_reg ? rd_data_reg : nos_reg;

    // ------------------------------------------------------------------------
    // Instruction decode and execute
    // ------------------------------------------------------------------------
    logic [OPCODE_W-1:0] op;
    logic [WORD_W-1:0]   arg;
    logic [CNT_W-1:0]    n_m2, n_m3;
    logic                target_ok;
    logic [IADDR_W-1:0]  ip_inc;

    logic [STATUS_W-1:0] ex_status;
    logic [CNT_W-1:0]    ex_cnt;
    logic [WORD_W-1:0]   ex_tos, ex_nos;
    logic                ex_fill;
    logic [IADDR_W-1:0]  ex_ip;
    logic                ex_pvalid;
    logic [WORD_W-1:0]   ex_pvalue;
    logic                ex_spill;

    assign op        = s_tuser;
    assign arg       = s_tdata;
    assign n_m2      = cnt_reg - CNT_TWO;
    assign n_m3      = cnt_reg - CNT_THREE;
    assign ip_inc    = ip_reg + IADDR_W'(1);
    assign target_ok = (arg[WORD_W-1:IADDR_W] == '0) && (arg[IADDR_W-1:0] < plen_reg);

    always_comb begin
        ex_status = ST_OK;
        ex_cnt    = cnt_reg;
        ex_tos    = tos_reg;
        ex_nos    = nos_eff;
        ex_fill   = 1'b0;
        ex_ip     = ip_inc;
        ex_pvalid = 1'b0;
        ex_pvalue = '0;
        ex_spill  = 1'b0;
        case (op)
            OP_PUSH, OP_DUP, OP_OVER: begin
                if ((op == OP_DUP && cnt_reg < CNT_ONE) ||
                    (op == OP_OVER && cnt_reg < CNT_TWO)) begin
                    ex_status = ST_UNDERFLOW;
                end else if (cnt_reg == DEPTH_CNT) begin
                    ex_status = ST_OVERFLOW;
                end else begin
                    ex_cnt   = cnt_reg + CNT_ONE;
                    ex_spill = (cnt_reg >= CNT_TWO);
                    ex_nos   = tos_reg;
                    if (op == OP_PUSH) begin
                        ex_tos = arg;
                    end else if (op == OP_OVER) begin
                        ex_tos = nos_eff;
                    end
                end
            end
            OP_DROP, OP_PRINT: begin
                if (cnt_reg < CNT_ONE) begin
                    ex_status = ST_UNDERFLOW;
                end else begin
                    ex_cnt  = cnt_reg - CNT_ONE;
                    ex_tos  = nos_eff;
                    ex_fill = (cnt_reg >= CNT_THREE);
                    if (op == OP_PRINT) begin
                        ex_pvalid = 1'b1;
                        ex_pvalue = tos_reg;
                    end
                end
            end
            OP_SWAP: begin
                if (cnt_reg < CNT_TWO) begin
                    ex_status = ST_UNDERFLOW;
                end else begin
                    ex_tos = nos_eff;
                    ex_nos = tos_reg;
                end
            end
            OP_NOT: begin
                if (cnt_reg < CNT_ONE) begin
                    ex_status = ST_UNDERFLOW;
                end else begin
                    ex_tos = {{(WORD_W-1){1'b0}}, (tos_reg == '0)};
                end
            end
            OP_EQUAL, OP_LT, OP_ADD: begin
                if (cnt_reg < CNT_TWO) begin
                    ex_status = ST_UNDERFLOW;
                end else begin
                    ex_cnt  = cnt_reg - CNT_ONE;
                    ex_fill = (cnt_reg >= CNT_THREE);
                    if (op == OP_EQUAL) begin
                        ex_tos = {{(WORD_W-1){1'b0}}, (nos_eff == tos_reg)};
                    end else if (op == OP_LT) begin
                        ex_tos = {{(WORD_W-1){1'b0}}, ($signed(nos_eff) < $signed(tos_reg))};
                    end else begin
                        ex_tos = nos_eff + tos_reg;
                    end
                end
            end
            OP_JUMP: begin
                if (!target_ok) begin
                    ex_status = ST_BADJUMP;
                end else begin
                    ex_ip = arg[IADDR_W-1:0];
                end
            end
            OP_JUMPIF: begin
                if (cnt_reg < CNT_ONE) begin
                    ex_status = ST_UNDERFLOW;
                end else if (!target_ok) begin
                    ex_status = ST_BADJUMP;
                end else begin
                    ex_cnt  = cnt_reg - CNT_ONE;
                    ex_tos  = nos_eff;
                    ex_fill = (cnt_reg >= CNT_THREE);
                    if (tos_reg != '0) begin
                        ex_ip = arg[IADDR_W-1:0];
                    end
                end
            end
            default: begin
                ex_status = ST_ILLEGAL;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Commit and result
    // ------------------------------------------------------------------------
    logic commit;

    assign commit = in_acc && !halt_reg && (ex_status == ST_OK);

    always_comb begin
        cnt_next  = cnt_reg;
        tos_next  = tos_reg;
        nos_next  = nos_eff;
        fill_next = 1'b0;
        ip_next   = ip_reg;
        halt_next = halt_reg;
        if (commit) begin
            cnt_next  = ex_cnt;
            tos_next  = ex_tos;
            nos_next  = ex_nos;
            fill_next = ex_fill;
            ip_next   = ex_ip;
        end else if (in_acc) begin
            halt_next = 1'b1;
        end

        res_next              = res_reg;
        res_next.status       = halt_reg ? ST_HALTED : ex_status;
        res_next.next_address = ip_next;
        res_next.print_valid  = commit && ex_pvalid;
        res_next.print_value  = commit ? ex_pvalue : '0;
        res_next.halted       = halt_next;
        res_next.finished     = (ip_next >= plen_reg);

        m_tvalid_next = in_acc || (m_tvalid_reg && !m_tready);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            fill_reg     <= 1'b0;
            ip_reg       <= '0;
            halt_reg     <= 1'b0;
            plen_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            fill_reg     <= fill_next;
            ip_reg       <= ip_next;
            halt_reg     <= halt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                plen_reg <= cfg_wr_data;
            end
        end
    end

    // Cached top pair and result payload
    always_ff @(posedge aclk) begin
        tos_reg <= tos_next;
        nos_reg <= nos_next;
        if (in_acc) begin
            res_reg <= res_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stack RAM: spill below the cached pair on push, refill on pop
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (commit && ex_spill) begin
            stack_mem[n_m2[ADDR_W-1:0]] <= nos_eff;
        end
        if (commit && ex_fill) begin
            rd_data_reg <= stack_mem[n_m3[ADDR_W-1:0]];
        end
    end

    // ------------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------------
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, res_reg.halted, res_reg.print_value, res_reg.next_address};
    assign m_tuser  = {res_reg.print_valid, res_reg.status};
    assign m_tlast  = res_reg.finished;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // A refill is only pending directly after an executed pop
    a_fill_after_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg |-> $past(commit))
        else $error("refill pending without a preceding pop");

    // Once halted, the machine stays halted until reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared without reset");

    // A request taken while halted reports the halted status
    a_halted_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && halt_reg) |=> (m_tvalid_reg && res_reg.status == ST_HALTED))
        else $error("halted machine did not report halted status");

    // A failing instruction leaves the pointer and stack depth untouched
    a_error_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && !commit) |=> (ip_reg == $past(ip_reg) && cnt_reg == $past(cnt_reg)))
        else $error("state changed on a failing instruction");

    // Stack depth never exceeds the RAM size
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (cnt_reg <= DEPTH_CNT))
        else $error("stack depth beyond RAM size");

endmodule

// File: tb/sv/tb_stack_machine_execute_unit.sv
// ============================================================================
// Stack machine execute unit - self-checking testbench
// Drives instruction requests into the unit and predicts every result from a
// cycle-free model of the operand stack, the instruction pointer and the halt
// flag. Short directed programs come first, then random error-free programs
// under several program lengths, and last a single fault that halts the
// machine, followed by requests the halted machine must ignore.
// ============================================================================
module tb_stack_machine_execute_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import smeu_pkg::*;

    // Shallow stack so that overflow is within reach of a short run
    localparam int TB_DEPTH = 16;
    localparam logic [OPCODE_W-1:0] OP_ILLEGAL_LO = 4'd12;
    localparam logic [OPCODE_W-1:0] OP_ILLEGAL_HI = 4'd15;
    localparam logic [WORD_W-1:0]   WORD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [WORD_W-1:0]   WORD_MIN = 64'h8000_0000_0000_0000;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [IADDR_W-1:0]    cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic [OPCODE_W-1:0]   s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;

    // Stimulus-side view of the stack, used to keep programs error free
    int                    gen_depth   = 0;
    logic [IADDR_W-1:0]    gen_len     = '0;
    bit                    no_idle     = 1'b0;
    int                    hold_cycles = 0;

    // ------------------------------------------------------------------------
    // Execution tracker: predicts one result per accepted request
    // ------------------------------------------------------------------------
    class exec_tracker;
        logic [WORD_W-1:0]  stk [TB_DEPTH];
        int unsigned        depth;
        logic [IADDR_W-1:0] ip;
        bit                 halt;
        logic [IADDR_W-1:0] prog_len;
        result_t            due_results [$];
        int                 errors;

        function void reset_state();
            depth    = 0;
            ip       = '0;
            halt     = 1'b0;
            prog_len = '0;
            errors   = 0;
            due_results.delete();
        endfunction

        function void set_length(logic [IADDR_W-1:0] len);
            prog_len = len;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function bit target_ok(logic [WORD_W-1:0] t);
            return !t[WORD_W-1] && (t < {48'd0, prog_len});
        endfunction

        // One instruction on the live machine; state changes only on success
        function logic [STATUS_W-1:0] execute(logic [OPCODE_W-1:0] op,
                                              logic [WORD_W-1:0] arg,
                                              output logic [WORD_W-1:0] shown,
                                              output bit shown_ok);
            int unsigned       n;
            logic [WORD_W-1:0] a;
            logic [WORD_W-1:0] b;
            n        = depth;
            shown    = '0;
            shown_ok = 1'b0;
            case (op)
                OP_PUSH: begin
                    if (n >= TB_DEPTH) return ST_OVERFLOW;
                    stk[n] = arg;
                    depth  = n + 1;
                end
                OP_DROP: begin
                    if (n < 1) return ST_UNDERFLOW;
                    depth = n - 1;
                end
                OP_DUP: begin
                    if (n < 1) return ST_UNDERFLOW;
                    if (n >= TB_DEPTH) return ST_OVERFLOW;
                    stk[n] = stk[n-1];
                    depth  = n + 1;
                end
                OP_SWAP: begin
                    if (n < 2) return ST_UNDERFLOW;
                    a        = stk[n-2];
                    stk[n-2] = stk[n-1];
                    stk[n-1] = a;
                end
                OP_OVER: begin
                    if (n < 2) return ST_UNDERFLOW;
                    if (n >= TB_DEPTH) return ST_OVERFLOW;
                    stk[n] = stk[n-2];
                    depth  = n + 1;
                end
                OP_NOT: begin
                    if (n < 1) return ST_UNDERFLOW;
                    stk[n-1] = (stk[n-1] == '0) ? 64'd1 : 64'd0;
                end
                OP_EQUAL, OP_LT, OP_ADD: begin
                    if (n < 2) return ST_UNDERFLOW;
                    a = stk[n-2];
                    b = stk[n-1];
                    if (op == OP_EQUAL)
                        a = (a == b) ? 64'd1 : 64'd0;
                    else if (op == OP_LT)
                        a = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
                    else
                        a = a + b;
                    stk[n-2] = a;
                    depth    = n - 1;
                end
                OP_JUMP: begin
                    if (!target_ok(arg)) return ST_BADJUMP;
                    ip = arg[IADDR_W-1:0];
                    return ST_OK;
                end
                OP_JUMPIF: begin
                    // underflow first, then the target even if not taken
                    if (n < 1) return ST_UNDERFLOW;
                    if (!target_ok(arg)) return ST_BADJUMP;
                    depth = n - 1;
                    if (stk[n-1] != '0) begin
                        ip = arg[IADDR_W-1:0];
                        return ST_OK;
                    end
                end
                OP_PRINT: begin
                    if (n < 1) return ST_UNDERFLOW;
                    shown    = stk[n-1];
                    shown_ok = 1'b1;
                    depth    = n - 1;
                end
                default: return ST_ILLEGAL;
            endcase
            ip = ip + 16'd1;
            return ST_OK;
        endfunction

        function void note_instr(logic [OPCODE_W-1:0] op, logic [WORD_W-1:0] arg);
            result_t           r;
            logic [STATUS_W-1:0] st;
            logic [WORD_W-1:0] shown;
            bit                shown_ok;
            shown    = '0;
            shown_ok = 1'b0;
            if (halt) begin
                st = ST_HALTED;
            end else begin
                st = execute(op, arg, shown, shown_ok);
                if (st != ST_OK) begin
                    halt     = 1'b1;
                    shown_ok = 1'b0;
                    shown    = '0;
                end
            end
            r.status       = st;
            r.next_address = ip;
            r.print_valid  = shown_ok;
            r.print_value  = shown_ok ? shown : '0;
            r.halted       = halt;
            r.finished     = (ip >= prog_len);
            due_results.push_back(r);
        endfunction

        function void cmp_field(string name, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, actual %0h",
                         $time, got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            cmp_field("status",       WORD_W'(want.status),       WORD_W'(got.status));
            cmp_field("next_address", WORD_W'(want.next_address), WORD_W'(got.next_address));
            cmp_field("print_valid",  WORD_W'(want.print_valid),  WORD_W'(got.print_valid));
            cmp_field("print_value",  want.print_value,           got.print_value);
            cmp_field("halted",       WORD_W'(want.halted),       WORD_W'(got.halted));
            cmp_field("finished",     WORD_W'(want.finished),     WORD_W'(got.finished));
        endfunction
    endclass

    exec_tracker tracker = new();

    stack_machine_execute_unit #(
        .STACK_DEPTH (TB_DEPTH)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // [63:0] operand
        .s_tuser     (s_tuser),      // [3:0] opcode
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),      // [15:0] next_address, [79:16] print_value,
                                     // [80] halted
        .m_tuser     (m_tuser),      // [2:0] status, [3] print_valid
        .m_tlast     (m_tlast)       // finished
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Monitor: note accepted requests, check accepted results
    always @(posedge aclk) begin
        result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_instr(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                got.status       = m_tuser[2:0];
                got.print_valid  = m_tuser[3];
                got.next_address = m_tdata[15:0];
                got.print_value  = m_tdata[79:16];
                got.halted       = m_tdata[80];
                got.finished     = m_tlast;
                tracker.check_result(got);
            end
        end
    end

    // Result sink: random back-pressure, with an occasional long hold-off
    initial begin : result_sink
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                gap         = hold_cycles;
                hold_cycles = 0;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 15);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one request and wait for it to be taken; tvalid is left high
    task automatic send_instr(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] arg);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= arg;
        do @(posedge aclk); while (!s_tready);
        case (op)
            OP_PUSH, OP_DUP, OP_OVER:                          gen_depth++;
            OP_DROP, OP_EQUAL, OP_LT, OP_ADD, OP_JUMPIF, OP_PRINT: gen_depth--;
            default: ;
        endcase
    endtask

    // Wait for every result, then a short settle before touching the register;
    // the task first lets the monitor note the last request
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.outstanding() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_length(input logic [IADDR_W-1:0] len);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.set_length(len);
        gen_len = len;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return 64'd1;
            2:       return WORD_MIN;
            3:       return WORD_MAX;
            4:       return 64'($urandom_range(0, 3));
            5:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // True when the instruction cannot fault on the planned stack
    function automatic bit op_fits(logic [OPCODE_W-1:0] op);
        case (op)
            OP_PUSH:                     return gen_depth < TB_DEPTH;
            OP_DUP:                      return gen_depth >= 1 && gen_depth < TB_DEPTH;
            OP_OVER:                     return gen_depth >= 2 && gen_depth < TB_DEPTH;
            OP_DROP, OP_NOT, OP_PRINT:   return gen_depth >= 1;
            OP_SWAP, OP_EQUAL, OP_LT, OP_ADD: return gen_depth >= 2;
            OP_JUMP:                     return gen_len != 0;
            OP_JUMPIF:                   return gen_depth >= 1 && gen_len != 0;
            default:                     return 1'b0;
        endcase
    endfunction

    task automatic send_random_instr(input int push_bias);
        logic [OPCODE_W-1:0] op;
        logic [WORD_W-1:0]   arg;
        do begin
            if ($urandom_range(0, 99) < push_bias)
                op = OP_PUSH;
            else
                op = 4'($urandom_range(0, 11));
        end while (!op_fits(op));
        if (op == OP_JUMP || op == OP_JUMPIF)
            arg = 64'($urandom_range(0, gen_len - 1));
        else
            arg = pick_word();
        send_instr(op, arg);
    endtask

    task automatic run_phase(input logic [IADDR_W-1:0] len, input int count,
                             input int push_bias);
        drain();
        write_length(len);
        repeat (count) send_random_instr(push_bias);
    endtask

    function automatic logic [WORD_W-1:0] bad_target();
        case ($urandom_range(0, 2))
            0:       return {1'b1, 31'($urandom), $urandom};
            1:       return {48'd0, gen_len};
            default: return {32'($urandom_range(1, 255)), $urandom};
        endcase
    endfunction

    // One fault of a random kind; the machine stays halted afterwards
    task automatic cause_halt();
        case ($urandom_range(0, 4))
            0: begin
                while (gen_depth < TB_DEPTH) send_instr(OP_PUSH, pick_word());
                case ($urandom_range(0, 2))
                    0:       send_instr(OP_PUSH, pick_word());
                    1:       send_instr(OP_DUP, pick_word());
                    default: send_instr(OP_OVER, pick_word());
                endcase
            end
            1: begin
                while (gen_depth > 0) send_instr(OP_DROP, pick_word());
                case ($urandom_range(0, 3))
                    0:       send_instr(OP_DROP, pick_word());
                    1:       send_instr(OP_SWAP, pick_word());
                    2:       send_instr(OP_PRINT, pick_word());
                    // empty stack takes precedence over a bad target
                    default: send_instr(OP_JUMPIF, bad_target());
                endcase
            end
            2: send_instr(OP_JUMP, bad_target());
            3: begin
                // bad target is caught even when the branch is not taken
                send_instr(OP_PUSH, '0);
                send_instr(OP_JUMPIF, bad_target());
            end
            default: send_instr(4'($urandom_range(OP_ILLEGAL_LO, OP_ILLEGAL_HI)), pick_word());
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        tracker.reset_state();
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: arithmetic and stack shuffles with no program loaded
        write_length(16'd0);
        send_instr(OP_PUSH,  WORD_MAX);
        send_instr(OP_PUSH,  WORD_MIN);
        send_instr(OP_LT,    '1);
        send_instr(OP_NOT,   '0);
        send_instr(OP_PUSH,  '1);
        send_instr(OP_ADD,   WORD_MIN);
        send_instr(OP_NOT,   WORD_MAX);
        send_instr(OP_PUSH,  WORD_MIN);
        send_instr(OP_PUSH,  WORD_MIN);
        send_instr(OP_ADD,   '0);
        send_instr(OP_DUP,   '1);
        send_instr(OP_EQUAL, '0);
        send_instr(OP_OVER,  '0);
        send_instr(OP_SWAP,  '1);
        send_instr(OP_PRINT, '0);
        send_instr(OP_DROP,  '0);
        send_instr(OP_PRINT, '1);

        // Directed: jumps at the top of the address space and pointer wrap
        drain();
        write_length(16'hFFFF);
        send_instr(OP_JUMP,   64'd65534);
        send_instr(OP_PUSH,   '0);
        send_instr(OP_DUP,    '0);
        send_instr(OP_JUMPIF, '0);
        send_instr(OP_PUSH,   64'd5);
        send_instr(OP_JUMPIF, 64'd100);
        send_instr(OP_JUMP,   '0);

        // Random error-free programs under a range of lengths
        run_phase(16'd1, 80, 30);
        run_phase(16'hFFFF, 80, 60);
        no_idle = 1'b1;
        run_phase(16'($urandom_range(2, 64)), 80, 40);
        // receiver stalls for a long stretch while requests keep coming
        drain();
        write_length(16'($urandom_range(1, 4000)));
        hold_cycles = 300;
        repeat (80) send_random_instr(40);
        no_idle = 1'b0;
        run_phase(16'($urandom_range(0, 65535)), 100, 35);
        run_phase(16'd0, 60, 40);
        run_phase(16'($urandom_range(1, 20)), 60, 20);

        // Single fault, then requests the halted machine ignores
        drain();
        write_length(16'($urandom_range(1, 500)));
        cause_halt();
        repeat (20) send_instr(4'($urandom_range(0, 15)), {$urandom, $urandom});

        // Wind down
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.outstanding() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
rtl/core/smeu_pkg.sv
rtl/core/stack_machine_execute_unit.sv
tb/sv/tb_stack_machine_execute_unit.sv
